### rtl/kmc_pkg.sv
// Shared constants, codes and types of the keyed message counter table.
package kmc_pkg;

  localparam int unsigned ENTRIES   = 32;
  localparam int unsigned KEY_BYTES = 8;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned DEV_W     = 8;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W    = $clog2(ENTRIES + 1);

  // Only the leading KEY_BYTES bytes of a key take part in matching.
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_BYTES));
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_COUNT = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_COUNT   = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_CLEARED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_HIT  = 2'd0,
    STAT_NEW  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DEV_W-1:0] dev;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic [KEY_W-1:0] key;
    logic [DEV_W-1:0] dev;
    logic [CNT_W-1:0] count;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] count_inc;
  } match_t;

endpackage

### rtl/kmc_if.sv
// Request and response channel interfaces of the keyed message counter table.
interface kmc_req_if import kmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [KEY_W-1:0] app_key;
  logic [DEV_W-1:0] dev_id;

  modport source (output valid, output req_type, output app_key, output dev_id,
                  input ready);
  modport sink   (input valid, input req_type, input app_key, input dev_id,
                  output ready);
endinterface

interface kmc_rsp_if import kmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [1:0]       status;
  logic [KEY_W-1:0] entry_key;
  logic [DEV_W-1:0] entry_dev;
  logic [CNT_W-1:0] msg_count;
  logic             last;

  modport source (output valid, output kind, output status, output entry_key,
                  output entry_dev, output msg_count, output last, input ready);
  modport sink   (input valid, input kind, input status, input entry_key,
                  input entry_dev, input msg_count, input last, output ready);
endinterface

### rtl/kmc_store.sv
// Entry store: one write port and one registered read port.
module kmc_store import kmc_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kmc_match.sv
// Shared compare and saturating increment unit applied to each scanned entry.
module kmc_match import kmc_pkg::*; (
  input  entry_t           entry_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [DEV_W-1:0] dev_i,
  output match_t           match_o
);

  assign match_o.hit       = (entry_i.key == key_i) && (entry_i.dev == dev_i);
  assign match_o.count_inc = (entry_i.count == CNT_MAX) ? entry_i.count
                                                        : entry_i.count + CNT_W'(1);

endmodule

### rtl/keyed_message_counter_table.sv
// Top level of the keyed message counter table: sequencer and response register.
//
// Requests arrive on req_i as valid/ready beats carrying req_type, app_key and
// dev_id; results leave on rsp_o as beats carrying kind, status, entry_key,
// entry_dev, msg_count and last. A count request walks the stored entries one
// per cycle through a single read port of the entry store and a shared compare
// and increment unit. Its single acknowledgement is registered, and the block
// is ready again once that beat has been loaded into the output register.
// A flush reads the entries newest first and sends one beat per cycle while
// the output register is free, the final one marked last, then empties the
// table; an empty table flushes as one beat of kind "empty". A clear request
// empties the table and gives no beat, and an unknown request type is dropped.
// The block takes one request at a time: req_i.ready is high only while the
// sequencer is idle. Results sit in an output register, so a stalled receiver
// simply holds the sequencer (a flush pauses on the current entry) and no
// beat is lost or repeated. Reset empties the table at once; stored entries
// are not cleared because slots at or above the fill level are never read.
module keyed_message_counter_table import kmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmc_req_if.sink   req_i,
  kmc_rsp_if.source rsp_o
);

  state_e            state_q, state_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DEV_W-1:0]  dev_q, dev_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  rsp_t              res_q, res_d;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic              accept;
  logic              out_free;
  logic              rsp_load;
  rsp_t              rsp_new;
  logic              last_idx;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;
  match_t            match;
  logic [KEY_W-1:0]  key_in;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign last_idx = (FILL_W'(idx_q) + FILL_W'(1)) == fill_q;
  assign key_in   = req_i.app_key & KEY_MASK;

  kmc_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_d),
    .rdata_o (mem_rdata)
  );

  kmc_match u_match (
    .entry_i (mem_rdata),
    .key_i   (key_q),
    .dev_i   (dev_q),
    .match_o (match)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_e'(req_i.req_type))
            REQ_COUNT: state_d = (fill_q == '0) ? ST_EMIT : ST_SCAN;
            REQ_FLUSH: state_d = (fill_q == '0) ? ST_EMIT : ST_FLUSH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match.hit || last_idx) begin
          state_d = ST_EMIT;
        end
      end
      ST_FLUSH: begin
        if (out_free && idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs of the sequencer.
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    key_d       = key_q;
    dev_d       = dev_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_q[IDX_W-1:0];
    mem_wdata   = '{key: key_q, dev: dev_q, count: CNT_W'(1)};
    rsp_load    = 1'b0;
    rsp_new     = res_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = key_in;
          dev_d = req_i.dev_id;
          case (req_e'(req_i.req_type))
            REQ_COUNT: begin
              idx_d = '0;
              if (fill_q == '0) begin
                // Empty table: the first entry goes straight in.
                mem_we    = 1'b1;
                mem_wdata = '{key: key_in, dev: req_i.dev_id, count: CNT_W'(1)};
                fill_d    = FILL_W'(1);
                res_d     = '{kind: KIND_COUNT, status: STAT_NEW, key: '0, dev: '0,
                              count: CNT_W'(1), last: 1'b1};
              end
            end
            REQ_FLUSH: begin
              idx_d = IDX_W'(fill_q - FILL_W'(1));
              res_d = '{kind: KIND_EMPTY, status: STAT_HIT, key: '0, dev: '0,
                        count: '0, last: 1'b1};
            end
            REQ_CLEAR: fill_d = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (match.hit) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = '{key: key_q, dev: dev_q, count: match.count_inc};
          res_d     = '{kind: KIND_COUNT, status: STAT_HIT, key: '0, dev: '0,
                        count: match.count_inc, last: 1'b1};
        end else if (last_idx) begin
          if (fill_q == FILL_W'(ENTRIES)) begin
            res_d = '{kind: KIND_COUNT, status: STAT_FULL, key: '0, dev: '0,
                      count: '0, last: 1'b1};
          end else begin
            mem_we = 1'b1;
            fill_d = fill_q + FILL_W'(1);
            res_d  = '{kind: KIND_COUNT, status: STAT_NEW, key: '0, dev: '0,
                       count: CNT_W'(1), last: 1'b1};
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        rsp_new = '{kind: KIND_ENTRY, status: STAT_HIT, key: mem_rdata.key,
                    dev: mem_rdata.dev, count: mem_rdata.count,
                    last: (idx_q == '0)};
        if (out_free) begin
          rsp_load = 1'b1;
          if (idx_q == '0) begin
            fill_d = '0;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        rsp_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
      rsp_d       = rsp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    dev_q <= dev_d;
    res_q <= res_d;
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.kind      = rsp_q.kind;
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.entry_key = rsp_q.key;
  assign rsp_o.entry_dev = rsp_q.dev;
  assign rsp_o.msg_count = rsp_q.count;
  assign rsp_o.last      = rsp_q.last;

  // The fill level never passes the table size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(ENTRIES))
    else $error("fill level beyond table size");

  // A scan only ever looks at occupied slots.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> FILL_W'(idx_q) < fill_q)
    else $error("scan index outside the occupied slots");

  // Sending the last flushed entry leaves the table empty.
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_load && state_q == ST_FLUSH && rsp_new.last) |=> fill_q == '0)
    else $error("table not empty after flush");

  // A clear request empties the table in the next cycle.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == REQ_CLEAR) |=> fill_q == '0)
    else $error("table not empty after clear");

  // A new beat is only loaded while the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !rsp_load)
    else $error("pending response overwritten");

endmodule
